// File: rtl/core/dagr_pkg.sv
// ----------------------------------------------------------------------------
// dagr_pkg
// Shared types and constants for the in-degree gated shortest-path block.
// ----------------------------------------------------------------------------
`default_nettype none

package dagr_pkg;

   // field widths fixed by the word formats
   localparam int unsigned VTX_W  = 16;
   localparam int unsigned DEG_W  = 16;
   localparam int unsigned WGT_W  = 16;
   localparam int unsigned DIST_W = 31;

   // default number of vertex entries in each store
   localparam int unsigned DAGR_MAX_VERTICES = 65536;

   // label value that stands for an unreachable vertex
   localparam logic [DIST_W-1:0] DIST_INF = 31'd2000000000;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_INIT  = 2'd0,
      REQ_RELAX = 2'd1,
      REQ_QUERY = 2'd2
   } req_kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_QUOT   = 2'd1,
      ST_REM    = 2'd2,
      ST_MODIFY = 2'd3
   } dagr_state_type;

endpackage

`default_nettype wire

// File: rtl/core/dagr_ram.sv
// ----------------------------------------------------------------------------
// dagr_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dagr_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_a,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/dag_edge_relaxation_top.sv
// ----------------------------------------------------------------------------
// dag_edge_relaxation_top
// Shortest-path edge relaxation over a topologically ordered edge stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word: init a vertex (label and pending
//   in-degree), relax an edge (tail, head, weight) or query a vertex.
//   rsp_* returns exactly one word per command: status flag, label and
//   remaining in-degree. csr_* writes the source vertex, whose init sets
//   its label to zero; write it only while no command is in flight.
// Sequence:
//   when the store depth is a power of two or at least 65536, the accept
//   cycle reads the tail on the first and the head on the second read port
//   of each store; the next cycle modifies and writes back the init vertex
//   or the head of an accepted relax and loads the result register. Other
//   depths first run the vertex-modulo reduction (reciprocal multiply, then
//   multiply-subtract), and the stores are read at its end.
//   One command is in the sequencer at a time; the next is accepted while
//   the result word still waits in the output register.
// Reset:
//   clears the sequencer, the result valid and the source vertex. The stores
//   are not cleared and no clearing pass runs; a vertex must be initialized
//   before it is read.
// Stall:
//   while rsp_tready is low the output word holds, and a finished command
//   waits in its write-back cycle until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dag_edge_relaxation_top
   import dagr_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = DAGR_MAX_VERTICES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // from_vertex, to_vertex, edge_weight, in_degree
   input  wire logic [1:0]  req_tuser,  // req_type
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,  // label_value, degree_left, zero pad
   output logic      [0:0]  rsp_tuser,  // status
   // source vertex register
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int unsigned IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam bit NEED_MOD = (MAX_VERTICES < (2 ** VTX_W)) &&
                             ((MAX_VERTICES & (MAX_VERTICES - 1)) != 0);

   dagr_state_type     state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0]   source_ff;

   // captured command fields
   req_kind_type       kind_ff;
   logic [VTX_W-1:0]   from_ff;
   logic [WGT_W-1:0]   weight_ff;
   logic [DEG_W-1:0]   indeg_ff;
   logic [IDX_W-1:0]   idx_a_ff, idx_b_ff;

   // result register payload
   logic               rsp_status_ff, rsp_status_in;
   logic [DIST_W-1:0]  rsp_label_ff, rsp_label_in;
   logic [DEG_W-1:0]   rsp_degree_ff, rsp_degree_in;

   // control
   logic               accept, rd_en, wr_en, load_rsp, out_free;
   logic [IDX_W-1:0]   idx_a_calc, idx_b_calc;

   // store ports
   logic [DIST_W-1:0]  dist_a, dist_b, dist_wr;
   logic [DEG_W-1:0]   deg_a, deg_b, deg_wr;
   logic [IDX_W-1:0]   wr_addr;
   logic               wr_req;
   logic [DIST_W:0]    path_sum;
   logic [DIST_W-1:0]  path_sat;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // vertex index into the stores
   if (NEED_MOD) begin : g_mod
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MAX_VERTICES) + 64'd1);
      logic [VTX_W-1:0] to_ff;
      logic [VTX_W-1:0] quot_a_ff, quot_b_ff;
      logic [47:0]      prod_a, prod_b;
      logic [31:0]      rem_a, rem_b;

      // head vertex held for the reduction
      always_ff @(posedge clock) begin
         if (accept) begin
            to_ff <= req_tdata[31:16];
         end
      end

      // quotient by reciprocal, exact for 16-bit vertices
      assign prod_a = 48'(from_ff) * 48'(RECIP);
      assign prod_b = 48'(to_ff) * 48'(RECIP);
      always_ff @(posedge clock) begin
         quot_a_ff <= prod_a[47:32];
         quot_b_ff <= prod_b[47:32];
      end

      // remainder
      assign rem_a = 32'(from_ff) - 32'(quot_a_ff) * 32'(MAX_VERTICES);
      assign rem_b = 32'(to_ff) - 32'(quot_b_ff) * 32'(MAX_VERTICES);
      assign idx_a_calc = rem_a[IDX_W-1:0];
      assign idx_b_calc = rem_b[IDX_W-1:0];
   end else begin : g_direct
      assign idx_a_calc = IDX_W'(req_tdata[15:0]);
      assign idx_b_calc = IDX_W'(req_tdata[31:16]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = NEED_MOD ? ST_QUOT : ST_MODIFY;
            end
         end
         ST_QUOT:   state_in = ST_REM;
         ST_REM:    state_in = ST_MODIFY;
         ST_MODIFY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            rd_en      = accept && !NEED_MOD;
         end
         ST_QUOT:   ;
         ST_REM:    rd_en = 1'b1;
         ST_MODIFY: load_rsp = out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // source vertex register
   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= '0;
      end else if (csr_wr_en) begin
         source_ff <= csr_wr_data;
      end
   end

   // capture the command word
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind_type'(req_tuser);
         from_ff   <= req_tdata[15:0];
         weight_ff <= req_tdata[47:32];
         indeg_ff  <= req_tdata[63:48];
      end
   end

   // hold the store indexes for write-back
   always_ff @(posedge clock) begin
      if (rd_en) begin
         idx_a_ff <= idx_a_calc;
         idx_b_ff <= idx_b_calc;
      end
   end

   // tail label plus weight, saturated at infinity
   assign path_sum = {1'b0, dist_a} + (DIST_W + 1)'(weight_ff);
   assign path_sat = (path_sum > (DIST_W + 1)'(DIST_INF)) ? DIST_INF : path_sum[DIST_W-1:0];

   // modify step
   always_comb begin
      wr_req        = 1'b0;
      wr_addr       = idx_a_ff;
      dist_wr       = dist_b;
      deg_wr        = deg_b;
      rsp_status_in = 1'b0;
      rsp_label_in  = '0;
      rsp_degree_in = '0;
      case (kind_ff)
         REQ_INIT: begin
            wr_req        = 1'b1;
            dist_wr       = (from_ff == source_ff) ? '0 : DIST_INF;
            deg_wr        = indeg_ff;
            rsp_label_in  = dist_wr;
            rsp_degree_in = indeg_ff;
         end
         REQ_RELAX: begin
            if (deg_a != '0) begin
               // tail still has pending in-edges
               rsp_status_in = 1'b1;
               rsp_label_in  = dist_b;
               rsp_degree_in = deg_a;
            end else begin
               wr_req        = 1'b1;
               wr_addr       = idx_b_ff;
               dist_wr       = (path_sat < dist_b) ? path_sat : dist_b;
               deg_wr        = (deg_b != '0) ? deg_b - DEG_W'(1) : '0;
               rsp_label_in  = dist_wr;
               rsp_degree_in = deg_wr;
            end
         end
         REQ_QUERY: begin
            rsp_label_in  = dist_a;
            rsp_degree_in = deg_a;
         end
         default: ;
      endcase
   end

   assign wr_en = load_rsp && wr_req;

   // label store
   dagr_ram #(
      .WIDTH (DIST_W),
      .DEPTH (MAX_VERTICES)
   ) u_dist_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (dist_wr),
      .rd_en     (rd_en),
      .rd_addr_a (idx_a_calc),
      .rd_addr_b (idx_b_calc),
      .rd_data_a (dist_a),
      .rd_data_b (dist_b)
   );

   // pending in-degree store
   dagr_ram #(
      .WIDTH (DEG_W),
      .DEPTH (MAX_VERTICES)
   ) u_deg_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (deg_wr),
      .rd_en     (rd_en),
      .rd_addr_a (idx_a_calc),
      .rd_addr_b (idx_b_calc),
      .rd_data_a (deg_a),
      .rd_data_b (deg_b)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_label_ff  <= rsp_label_in;
         rsp_degree_ff <= rsp_degree_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_degree_ff, rsp_label_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// File: rtl/core/dagr_checker.sv
// ----------------------------------------------------------------------------
// dagr_checker
// Port-level checks of the shortest-path block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dagr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one command in the sequencer at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while another is in flight");

   // the result word does not rise in the cycle after the accept
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result word appeared too early");

   // no padding bit is ever set
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[47])
      else $error("result padding bit set");

endmodule

bind dag_edge_relaxation_top dagr_checker u_dagr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the in-degree gated shortest-path relaxation block.
// A short table of commands hits the field extremes, refused edges, label
// saturation, self-loops and unknown command kinds. Random phases follow:
// each writes a new source vertex, initializes a small DAG and relaxes its
// edges in topological order, with queries and noise mixed in. Every result
// word must match its pinned value or a copy of the label and degree stores.
// ----------------------------------------------------------------------------

module tb;
   import dagr_pkg::*;

   // command kind outside the defined set, must leave the stores alone
   localparam logic [1:0] REQ_UNKNOWN      = 2'd3;
   localparam logic       STATUS_OK        = 1'b0;
   localparam logic       STATUS_NOT_READY = 1'b1;
   localparam int         DAG_MAX          = 10;

   typedef struct packed {
      logic              status;
      logic [DIST_W-1:0] label;
      logic [DEG_W-1:0]  degree;
   } vertex_report_type;

   typedef struct {
      logic [1:0]        kind;
      logic [15:0]       from_v;
      logic [15:0]       to_v;
      logic [15:0]       wgt;
      logic [15:0]       deg;
      bit                pinned;
      vertex_report_type rep;
   } plan_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // expectation typed into the table, travels alongside the command word
   bit                pin_valid  = 1'b0;
   vertex_report_type pin_report = '0;

   // local copy of the stores and the source register
   logic [DIST_W-1:0] label_mem  [0:65535];
   logic [DEG_W-1:0]  degree_mem [0:65535];
   logic [15:0]       cfg_source;

   vertex_report_type reports_due [$];
   int                fail_count     = 0;
   int                commands_sent  = 0;
   bit                no_idle        = 1'b0;
   int unsigned       rsp_stall_left = 0;

   // generator side bookkeeping: which vertices have been initialized
   bit          init_done [0:65535];
   int unsigned known_vtx [$];
   logic [15:0] cur_source = '0;

   plan_row_type directed_plan [18];

   dag_edge_relaxation_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // apply one command to the local stores and return the result word
   function automatic vertex_report_type advance_store(input logic [1:0] kind,
                                                       input logic [15:0] tail,
                                                       input logic [15:0] head,
                                                       input logic [15:0] wgt,
                                                       input logic [15:0] deg);
      vertex_report_type r;
      logic [31:0]       sum;
      r = '0;
      case (kind)
         REQ_INIT: begin
            label_mem[tail]  = (tail == cfg_source) ? '0 : DIST_INF;
            degree_mem[tail] = deg;
            r.label  = label_mem[tail];
            r.degree = deg;
         end
         REQ_RELAX: begin
            if (degree_mem[tail] != 0) begin
               r.status = STATUS_NOT_READY;
               r.label  = label_mem[head];
               r.degree = degree_mem[tail];
            end else begin
               sum = {1'b0, label_mem[tail]} + {16'd0, wgt};
               if (sum > {1'b0, DIST_INF}) sum = {1'b0, DIST_INF};
               if (sum[30:0] < label_mem[head]) label_mem[head] = sum[30:0];
               // decrement saturates at zero
               if (degree_mem[head] != 0) degree_mem[head] = degree_mem[head] - 1'b1;
               r.label  = label_mem[head];
               r.degree = degree_mem[head];
            end
         end
         REQ_QUERY: begin
            r.label  = label_mem[tail];
            r.degree = degree_mem[tail];
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // scoreboard: check result words, then predict for the accepted command word
   always @(posedge clock) begin : scoreboard
      vertex_report_type got;
      vertex_report_type want;
      if (reset) begin
         cfg_source = '0;
      end else begin
         if (csr_wr_en) cfg_source = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser[0], rsp_tdata[30:0], rsp_tdata[46:31]};
            if (reports_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: status %0d label %0d degree %0d",
                           got.status, got.label, got.degree);
            end else begin
               want = reports_due.pop_front();
               if (got.status !== want.status || got.label !== want.label ||
                   got.degree !== want.degree) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp st %0d lab %0d deg %0d, got st %0d lab %0d deg %0d",
                              want.status, want.label, want.degree,
                              got.status, got.label, got.degree);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = advance_store(req_tuser, req_tdata[15:0], req_tdata[31:16],
                                 req_tdata[47:32], req_tdata[63:48]);
            if (pin_valid) want = pin_report;
            reports_due.push_back(want);
         end
      end
   end

   // result side back-pressure: mostly ready, short stalls, a few long ones
   always @(posedge clock) begin : rsp_backpressure
      int unsigned pick;
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle) begin
            pick = $urandom_range(0, 15);
            if (pick == 15)
               rsp_stall_left <= $urandom_range(20, 60);
            else if (pick >= 12)
               rsp_stall_left <= $urandom_range(1, 3);
         end
      end
   end

   // drive one command word after a random gap, return once it is accepted
   task automatic send_word(input logic [1:0] kind, input logic [15:0] from_v,
                            input logic [15:0] to_v, input logic [15:0] wgt,
                            input logic [15:0] deg, input bit pinned,
                            input vertex_report_type rep);
      int unsigned gap;
      int unsigned pick;
      gap = 0;
      if (!no_idle) begin
         pick = $urandom_range(0, 15);
         if (pick >= 9 && pick < 14)
            gap = $urandom_range(1, 3);
         else if (pick == 14)
            gap = $urandom_range(4, 8);
         else if (pick == 15)
            gap = $urandom_range(20, 50);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {deg, wgt, to_v, from_v};
      req_tuser  <= kind;
      pin_valid  <= pinned;
      pin_report <= rep;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      commands_sent++;
   endtask

   task automatic mark_known(input logic [15:0] v);
      if (!init_done[v]) begin
         init_done[v] = 1'b1;
         known_vtx.push_back(v);
      end
   endtask

   // init with random filler in the unused fields
   task automatic send_init(input logic [15:0] v, input logic [15:0] deg);
      send_word(REQ_INIT, v, 16'($urandom), 16'($urandom), deg, 1'b0, '0);
      mark_known(v);
   endtask

   function automatic logic [15:0] any_known();
      return 16'(known_vtx[$urandom_range(0, known_vtx.size() - 1)]);
   endfunction

   // stray traffic: queries, unknown kinds, arbitrary edges, fresh inits
   task automatic send_noise();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick < 3)
         send_word(REQ_QUERY, any_known(), 16'($urandom), 16'($urandom),
                   16'($urandom), 1'b0, '0);
      else if (pick < 5)
         send_word(REQ_UNKNOWN, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 1'b0, '0);
      else if (pick < 7)
         send_word(REQ_RELAX, any_known(), any_known(), 16'($urandom),
                   16'($urandom), 1'b0, '0);
      else
         send_init(16'($urandom), 16'($urandom));
   endtask

   // wait until the block is idle with nothing outstanding
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_source(input logic [15:0] v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_source   = v;
   endtask

   // stimulus
   initial begin : stimulus
      int          phase;
      int          n;
      int          k;
      int          j;
      bit          dup;
      logic [15:0] dag_ids  [DAG_MAX];
      bit          dag_edge [DAG_MAX][DAG_MAX];
      logic [15:0] dag_deg  [DAG_MAX];
      logic [15:0] wgt;

      // source is 0 after reset
      directed_plan = '{
         '{REQ_INIT,    16'd0,     16'd0,     16'd0,     16'd0,     1'b1,
           '{STATUS_OK, 31'd0, 16'd0}},
         '{REQ_INIT,    16'd65535, 16'd0,     16'd0,     16'd65535, 1'b1,
           '{STATUS_OK, DIST_INF, 16'd65535}},
         '{REQ_QUERY,   16'd65535, 16'd0,     16'd0,     16'd0,     1'b1,
           '{STATUS_OK, DIST_INF, 16'd65535}},
         '{REQ_RELAX,   16'd0,     16'd65535, 16'd65535, 16'd0,     1'b0, '0},
         // tail still has pending edges: refused
         '{REQ_RELAX,   16'd65535, 16'd0,     16'd0,     16'd65535, 1'b0, '0},
         '{REQ_INIT,    16'd1,     16'd65535, 16'd65535, 16'd1,     1'b1,
           '{STATUS_OK, DIST_INF, 16'd1}},
         '{REQ_RELAX,   16'd0,     16'd1,     16'd0,     16'd0,     1'b0, '0},
         // self-loop, degree already zero
         '{REQ_RELAX,   16'd1,     16'd1,     16'd5,     16'd0,     1'b0, '0},
         '{REQ_INIT,    16'd2,     16'd0,     16'd0,     16'd0,     1'b1,
           '{STATUS_OK, DIST_INF, 16'd0}},
         // infinite tail plus weight saturates
         '{REQ_RELAX,   16'd2,     16'd1,     16'd65535, 16'd0,     1'b0, '0},
         '{REQ_INIT,    16'd3,     16'd0,     16'd0,     16'd2,     1'b1,
           '{STATUS_OK, DIST_INF, 16'd2}},
         '{REQ_RELAX,   16'd2,     16'd3,     16'd65535, 16'd0,     1'b0, '0},
         // unknown kind gives an all-zero word
         '{REQ_UNKNOWN, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1,
           '{STATUS_OK, 31'd0, 16'd0}},
         '{REQ_UNKNOWN, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1,
           '{STATUS_OK, 31'd0, 16'd0}},
         '{REQ_RELAX,   16'd0,     16'd3,     16'd1,     16'd0,     1'b0, '0},
         '{REQ_QUERY,   16'd3,     16'd0,     16'd0,     16'd0,     1'b0, '0},
         '{REQ_RELAX,   16'd3,     16'd65535, 16'd100,   16'd0,     1'b0, '0},
         '{REQ_QUERY,   16'd0,     16'd65535, 16'd65535, 16'd65535, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_plan[i]) begin
         send_word(directed_plan[i].kind, directed_plan[i].from_v, directed_plan[i].to_v,
                   directed_plan[i].wgt, directed_plan[i].deg, directed_plan[i].pinned,
                   directed_plan[i].rep);
         if (directed_plan[i].kind == REQ_INIT) mark_known(directed_plan[i].from_v);
      end

      // random phases, one DAG per source setting
      phase = 0;
      while (commands_sent < 820) begin
         no_idle = (phase % 5 == 3);
         if (phase == 0)
            write_source(16'd65535);
         else if (phase == 1)
            write_source(16'd0);
         else if ($urandom_range(0, 3) == 0)
            write_source(any_known());
         else
            write_source(16'($urandom));

         // pick distinct vertices, the first usually the source
         n = $urandom_range(2, DAG_MAX);
         for (k = 0; k < n; k++) begin
            do begin
               if (k == 0 && $urandom_range(0, 3) != 0)
                  dag_ids[k] = cur_source;
               else if ($urandom_range(0, 7) == 0)
                  dag_ids[k] = ($urandom_range(0, 1) != 0) ? 16'd65535 : 16'd0;
               else
                  dag_ids[k] = 16'($urandom);
               dup = 1'b0;
               for (j = 0; j < k; j++)
                  if (dag_ids[j] == dag_ids[k]) dup = 1'b1;
            end while (dup);
         end

         // edges go from lower to higher position only
         for (k = 0; k < n; k++) dag_deg[k] = '0;
         for (k = 0; k < n; k++)
            for (j = 0; j < n; j++) begin
               dag_edge[k][j] = (j > k) && ($urandom_range(0, 2) != 0);
               if (dag_edge[k][j]) dag_deg[j]++;
            end
         // now and then one vertex never becomes ready
         if ($urandom_range(0, 7) == 0) dag_deg[$urandom_range(0, n - 1)]++;

         for (k = 0; k < n; k++) send_init(dag_ids[k], dag_deg[k]);

         // relax in topological order with stray traffic in between
         for (k = 0; k < n; k++)
            for (j = k + 1; j < n; j++)
               if (dag_edge[k][j]) begin
                  if ($urandom_range(0, 5) == 0) send_noise();
                  wgt = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 1000));
                  send_word(REQ_RELAX, dag_ids[k], dag_ids[j], wgt, 16'($urandom),
                            1'b0, '0);
               end

         for (k = 0; k < n; k++)
            send_word(REQ_QUERY, dag_ids[k], 16'($urandom), 16'($urandom),
                      16'($urandom), 1'b0, '0);
         repeat ($urandom_range(0, 3)) send_noise();
         phase++;
      end

      no_idle = 1'b0;
      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && reports_due.size() == 0)
         $display("dag_edge_relaxation_top test passed");
      else
         $display("dag_edge_relaxation_top test failed");
      $finish;
   end

   // timeout
   initial begin : watchdog
      #2000000;
      $display("dag_edge_relaxation_top test failed");
      $finish;
   end

endmodule
